/* sv/lfrc_pkg.sv */
// shared types, constants and crc helpers for the length framed receiver
`default_nettype none

package lfrc_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 9;
    localparam int CRC_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SOF_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 1'd1;

    localparam logic [BYTE_W-1:0] SOF_BYTE_RST   = 8'd104;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 9'd256;
    localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
    localparam logic [9:0]        FRAME_OVERHEAD = 10'd4;

    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_CRC  = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] byte_value;
    } lfrc_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] body_length;
        logic [CRC_W-1:0]  computed_crc;
        logic [CRC_W-1:0]  received_crc;
    } lfrc_out_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sof_byte;
        logic [LEN_W-1:0]  max_frame_len;
    } lfrc_cfg_t;

    function automatic logic [CRC_W-1:0] nib_tab(input logic [3:0] idx);
        logic [CRC_W-1:0] v;
        begin
            case (idx)
                4'h0: v = 16'h0000;
                4'h1: v = 16'hCC01;
                4'h2: v = 16'hD801;
                4'h3: v = 16'h1400;
                4'h4: v = 16'hF001;
                4'h5: v = 16'h3C00;
                4'h6: v = 16'h2800;
                4'h7: v = 16'hE401;
                4'h8: v = 16'hA001;
                4'h9: v = 16'h6C00;
                4'hA: v = 16'h7800;
                4'hB: v = 16'hB401;
                4'hC: v = 16'h5000;
                4'hD: v = 16'h9C01;
                4'hE: v = 16'h8801;
                4'hF: v = 16'h4400;
                default: v = 16'h0000;
            endcase
            return v;
        end
    endfunction

    // two table steps, low nibble first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c1;
        logic [CRC_W-1:0] c2;
        begin
            c1 = nib_tab(b[3:0] ^ crc[3:0]) ^ (crc >> 4);
            c2 = nib_tab(b[7:4] ^ c1[3:0]) ^ (c1 >> 4);
            return c2;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/lfrc_cfg.sv */
// configuration registers: start code and frame length limit
`default_nettype none

module lfrc_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lfrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lfrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output lfrc_pkg::lfrc_cfg_t                    cfg
);
    import lfrc_pkg::*;

    logic [BYTE_W-1:0] sof_byte_reg;
    logic [LEN_W-1:0]  max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_byte_reg <= SOF_BYTE_RST;
            max_len_reg  <= MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOF_BYTE: sof_byte_reg <= cfg_wdata[BYTE_W-1:0];
                CFG_MAX_LEN:  max_len_reg  <= cfg_wdata[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg.sof_byte      = sof_byte_reg;
    assign cfg.max_frame_len = max_len_reg;

endmodule

`default_nettype wire

/* sv/lfrc_frame.sv */
// frame state machine with running crc and verdict generation
`default_nettype none

module lfrc_frame (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  lfrc_pkg::lfrc_cfg_t      cfg,
    input  lfrc_pkg::lfrc_in_t       beat,
    input  wire logic                go,
    output logic                     res_valid,
    output lfrc_pkg::lfrc_out_t      res
);
    import lfrc_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] hdr_len_reg, hdr_len_next;
    logic [LEN_W-1:0]  seen_reg, seen_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] low_reg, low_next;
    logic [CRC_W-1:0]  rx_crc;

    assign rx_crc = {beat.byte_value, low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            hdr_len_reg <= '0;
            seen_reg    <= '0;
            crc_reg     <= CRC_INIT;
            low_reg     <= '0;
        end
        else if (go)
        begin
            phase_reg   <= phase_next;
            hdr_len_reg <= hdr_len_next;
            seen_reg    <= seen_next;
            crc_reg     <= crc_next;
            low_reg     <= low_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_len_next = hdr_len_reg;
        seen_next    = seen_reg;
        crc_next     = crc_reg;
        low_next     = low_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (beat.mode == MODE_TIMEOUT)
        begin
            phase_next   = PH_HUNT;
            hdr_len_next = '0;
            seen_next    = '0;
            crc_next     = CRC_INIT;
            low_next     = '0;
        end
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    hdr_len_next = beat.byte_value;
                    if ({2'b00, beat.byte_value} + FRAME_OVERHEAD > {1'b0, cfg.max_frame_len})
                    begin
                        res_valid        = 1'b1;
                        res.status       = ST_TOO_LONG;
                        res.body_length  = beat.byte_value;
                        phase_next   = PH_HUNT;
                        hdr_len_next = '0;
                        seen_next    = '0;
                        crc_next     = CRC_INIT;
                        low_next     = '0;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        seen_next  = '0;
                        crc_next   = CRC_INIT;
                    end
                end
                PH_BODY:
                begin
                    if (seen_reg < {1'b0, hdr_len_reg})
                    begin
                        crc_next  = crc_byte(crc_reg, beat.byte_value);
                        seen_next = seen_reg + 1'b1;
                    end
                    else if (seen_reg == {1'b0, hdr_len_reg})
                    begin
                        low_next  = beat.byte_value;
                        seen_next = seen_reg + 1'b1;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.status       = (rx_crc == crc_reg) ? ST_GOOD : ST_BAD_CRC;
                        res.body_length  = hdr_len_reg;
                        res.computed_crc = crc_reg;
                        res.received_crc = rx_crc;
                        phase_next   = PH_HUNT;
                        hdr_len_next = '0;
                        seen_next    = '0;
                        crc_next     = CRC_INIT;
                        low_next     = '0;
                    end
                end
                default:
                begin
                    phase_next   = (beat.byte_value == cfg.sof_byte) ? PH_LEN : PH_HUNT;
                    hdr_len_next = '0;
                    seen_next    = '0;
                    crc_next     = CRC_INIT;
                    low_next     = '0;
                end
            endcase
        end
    end

    a_timeout_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        go && beat.mode == MODE_TIMEOUT |=> phase_reg == PH_HUNT)
        else $error("timeout did not return to hunting");

    a_crc_idle_init: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_BODY |-> crc_reg == CRC_INIT)
        else $error("crc not at start value outside a body");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> seen_reg <= {1'b0, hdr_len_reg} + 9'd1)
        else $error("byte count ran past frame end");

    a_long_zero_crc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_TOO_LONG
            |-> res.computed_crc == '0 && res.received_crc == '0 && phase_reg == PH_LEN)
        else $error("too long verdict carries crc or came from wrong phase");

endmodule

`default_nettype wire

/* sv/lfrc_out.sv */
// result register toward the output channel
`default_nettype none

module lfrc_out (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  lfrc_pkg::lfrc_out_t  res,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output lfrc_pkg::lfrc_out_t  out_data
);
    import lfrc_pkg::*;

    logic      vld_reg, vld_next;
    lfrc_out_t data_reg;

    assign room = !vld_reg || !out_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
            vld_next = 1'b1;
        else if (vld_reg && !out_stall)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* sv/length_framed_receiver_crc16.sv */
// top level of the length framed receiver with crc-16 check
// a verdict is formed from the input register by the frame logic and loaded into the result register
// throughput: one beat per cycle; the input register advances whenever the
// result register has room, gated only by a pending verdict under stall
// reset: rst_n clears both pipeline valids, returns to hunting with crc 0xFFFF,
// and loads start code 104 and frame limit 256
`default_nettype none

module length_framed_receiver_crc16 (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  lfrc_pkg::lfrc_in_t                     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output lfrc_pkg::lfrc_out_t                    out_data,
    input  wire logic                              cfg_we,
    input  wire logic [lfrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lfrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import lfrc_pkg::*;

    lfrc_cfg_t cfg;
    lfrc_in_t  in_reg;
    logic      in_vld_reg, in_vld_next;
    logic      res_valid;
    lfrc_out_t res;
    logic      room;
    logic      move;
    logic      take;

    lfrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign move     = in_vld_reg && (!res_valid || room);
    assign in_stall = in_vld_reg && !move;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
            in_vld_next = 1'b1;
        else if (move)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= in_data;
    end

    lfrc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .beat      (in_reg),
        .go        (move),
        .res_valid (res_valid),
        .res       (res)
    );

    lfrc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move && res_valid),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
